// ----- rtl/manifest_chunk_locator_top_assert.svh -----
// Assertion macros for the manifest chunk locator.
// Both macros sample on clk_i and are disabled while rst_ni is low.
`ifndef MANIFEST_CHUNK_LOCATOR_TOP_ASSERT_SVH
`define MANIFEST_CHUNK_LOCATOR_TOP_ASSERT_SVH

`define MCL_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

`define MCL_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- rtl/mcl_pkg.sv -----
package mcl_pkg;

  typedef enum logic [2:0] {
    StatFound      = 3'd0,
    StatEnvEnd     = 3'd1,
    StatChunkLimit = 3'd2,
    StatOverrun    = 3'd3,
    StatTruncated  = 3'd4
  } status_e;

  typedef struct packed {
    status_e     status;
    logic [7:0]  version;
    logic [16:0] data_offset;
    logic [15:0] data_len;
    logic [7:0]  chunk_number;
  } result_t;

  localparam int unsigned QueueDepth = 2;
  localparam logic [7:0] ChunkLimit = 8'd10;
  localparam logic [17:0] ChunkHeaderBytes = 18'd3;
  localparam logic [16:0] DataOffsetAdj = 17'd6;

endpackage

// ----- rtl/mcl_parser.sv -----
module mcl_parser (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            accept_i,
  input  logic [7:0]      data_byte_i,
  input  logic            last_byte_i,
  input  logic [7:0]      target_type_i,
  output logic            res_push_o,
  output mcl_pkg::result_t res_o
);

  typedef enum logic [2:0] {
    PhVersion = 3'd0,
    PhEnvLo   = 3'd1,
    PhEnvHi   = 3'd2,
    PhType    = 3'd3,
    PhLenLo   = 3'd4,
    PhLenHi   = 3'd5,
    PhSkip    = 3'd6
  } phase_e;

  phase_e      phase_q, phase_d;
  logic [15:0] env_q, env_d;
  logic [15:0] pos_q, pos_d;
  logic [7:0]  count_q, count_d;
  logic [7:0]  kind_q, kind_d;
  logic [7:0]  len_lo_q, len_lo_d;
  logic [15:0] skip_q, skip_d;
  logic [7:0]  version_q, version_d;
  logic        decided_q, decided_d;

  logic             emit;
  mcl_pkg::status_e emit_status;
  logic [16:0]      emit_offset;
  logic [15:0]      emit_len;
  logic [7:0]       emit_version;
  logic [7:0]       emit_count;

  always_comb begin
    logic [15:0] env_full;
    logic [15:0] len_full;
    logic [17:0] chunk_end;
    logic [15:0] skip_next;
    logic [7:0]  count_inc;
    env_full  = {data_byte_i, env_q[7:0]};
    len_full  = {data_byte_i, len_lo_q};
    chunk_end = {2'b00, pos_q} + {2'b00, len_full} + mcl_pkg::ChunkHeaderBytes;
    skip_next = skip_q - 16'd1;
    count_inc = count_q + 8'd1;

    phase_d     = phase_q;
    env_d       = env_q;
    pos_d       = pos_q;
    count_d     = count_q;
    kind_d      = kind_q;
    len_lo_d    = len_lo_q;
    skip_d      = skip_q;
    version_d   = version_q;
    emit        = 1'b0;
    emit_status = mcl_pkg::StatFound;
    emit_offset = '0;
    emit_len    = '0;

    if (!decided_q) begin
      unique case (phase_q)
        PhVersion: begin
          version_d = data_byte_i;
          phase_d   = PhEnvLo;
        end
        PhEnvLo: begin
          env_d   = {8'h00, data_byte_i};
          phase_d = PhEnvHi;
        end
        PhEnvHi: begin
          env_d = env_full;
          if (pos_q >= env_full) begin
            emit        = 1'b1;
            emit_status = mcl_pkg::StatEnvEnd;
          end else if (count_q >= mcl_pkg::ChunkLimit) begin
            emit        = 1'b1;
            emit_status = mcl_pkg::StatChunkLimit;
          end else begin
            phase_d = PhType;
          end
        end
        PhType: begin
          kind_d  = data_byte_i;
          phase_d = PhLenLo;
        end
        PhLenLo: begin
          len_lo_d = data_byte_i;
          phase_d  = PhLenHi;
        end
        PhLenHi: begin
          if (kind_q == target_type_i) begin
            emit = 1'b1;
            if (chunk_end <= ({2'b00, env_q} + 18'd1)) begin
              emit_status = mcl_pkg::StatFound;
              emit_offset = {1'b0, pos_q} + mcl_pkg::DataOffsetAdj;
              emit_len    = len_full;
            end else begin
              emit_status = mcl_pkg::StatOverrun;
            end
          end else if (chunk_end > 18'h0FFFF) begin
            emit        = 1'b1;
            emit_status = mcl_pkg::StatOverrun;
          end else begin
            pos_d   = chunk_end[15:0];
            count_d = count_inc;
            if (chunk_end[15:0] >= env_q) begin
              emit        = 1'b1;
              emit_status = mcl_pkg::StatEnvEnd;
            end else if (count_inc >= mcl_pkg::ChunkLimit) begin
              emit        = 1'b1;
              emit_status = mcl_pkg::StatChunkLimit;
            end else if (len_full != 16'd0) begin
              skip_d  = len_full;
              phase_d = PhSkip;
            end else begin
              phase_d = PhType;
            end
          end
        end
        PhSkip: begin
          skip_d = skip_next;
          if (skip_next == 16'd0) begin
            phase_d = PhType;
          end
        end
        default: begin
          phase_d = PhVersion;
        end
      endcase
    end

    if (last_byte_i && !decided_q && !emit) begin
      emit        = 1'b1;
      emit_status = mcl_pkg::StatTruncated;
      emit_offset = '0;
      emit_len    = '0;
    end

    decided_d = decided_q | emit;

    // Version and chunk count are reported as they stand after this byte.
    emit_version = version_d;
    emit_count   = count_d;

    if (last_byte_i) begin
      phase_d   = PhVersion;
      env_d     = '0;
      pos_d     = '0;
      count_d   = '0;
      kind_d    = '0;
      len_lo_d  = '0;
      skip_d    = '0;
      version_d = '0;
      decided_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q    <= PhVersion;
      env_q      <= '0;
      pos_q      <= '0;
      count_q    <= '0;
      kind_q     <= '0;
      len_lo_q   <= '0;
      skip_q     <= '0;
      version_q  <= '0;
      decided_q  <= 1'b0;
    end else if (accept_i) begin
      phase_q    <= phase_d;
      env_q      <= env_d;
      pos_q      <= pos_d;
      count_q    <= count_d;
      kind_q     <= kind_d;
      len_lo_q   <= len_lo_d;
      skip_q     <= skip_d;
      version_q  <= version_d;
      decided_q  <= decided_d;
    end
  end

  assign res_push_o         = accept_i & emit;
  assign res_o.status       = emit_status;
  assign res_o.version      = emit_version;
  assign res_o.data_offset  = emit_offset;
  assign res_o.data_len     = emit_len;
  assign res_o.chunk_number = emit_count;

endmodule

// ----- rtl/mcl_queue.sv -----
module mcl_queue #(
  parameter int unsigned Depth = mcl_pkg::QueueDepth
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  mcl_pkg::result_t data_i,
  input  logic             pop_i,
  output mcl_pkg::result_t data_o,
  output logic             empty_o,
  output logic             full_o
);

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);
  localparam logic [PtrW-1:0] LastPtr = PtrW'(Depth - 1);
  localparam logic [CntW-1:0] FullCnt = CntW'(Depth);

  mcl_pkg::result_t slots_q [Depth];
  logic [PtrW-1:0]  wptr_q, rptr_q;
  logic [CntW-1:0]  cnt_q;
  logic             do_push, do_pop;

  assign empty_o = (cnt_q == '0);
  assign full_o  = (cnt_q == FullCnt);
  assign do_push = push_i & ~full_o;
  assign do_pop  = pop_i & ~empty_o;
  assign data_o  = slots_q[rptr_q];

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      slots_q[wptr_q] <= data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      if (do_push) begin
        wptr_q <= (wptr_q == LastPtr) ? '0 : wptr_q + PtrW'(1);
      end
      if (do_pop) begin
        rptr_q <= (rptr_q == LastPtr) ? '0 : rptr_q + PtrW'(1);
      end
      if (do_push && !do_pop) begin
        cnt_q <= cnt_q + CntW'(1);
      end else if (do_pop && !do_push) begin
        cnt_q <= cnt_q - CntW'(1);
      end
    end
  end

endmodule

// ----- rtl/manifest_chunk_locator_top.sv -----
// Accepts one manifest byte per cycle while full_o is low; each byte is parsed in the cycle it is taken.
// A result is written into a queue slot at the edge that accepts its deciding byte and
// reaches the result ports from that slot once the results ahead of it are popped.
// full_o rises only when QueueDepth results wait unpopped; the queue depth sets that bound.
// Reset clears the parser, the queue and target_type, which returns to zero.
module manifest_chunk_locator_top #(
  parameter int unsigned QueueDepth = mcl_pkg::QueueDepth
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [7:0]  cfg_data_i,
  input  logic        push_i,
  output logic        full_o,
  input  logic [7:0]  data_byte_i,
  input  logic        last_byte_i,
  output logic        empty_o,
  input  logic        pop_i,
  output logic [2:0]  status_o,
  output logic [7:0]  version_o,
  output logic [16:0] data_offset_o,
  output logic [15:0] data_len_o,
  output logic [7:0]  chunk_number_o
);

  `include "manifest_chunk_locator_top_assert.svh"

  logic [7:0]       target_type_q;
  logic             accept;
  logic             res_push;
  mcl_pkg::result_t res_in, res_out;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      target_type_q <= '0;
    end else if (cfg_we_i) begin
      target_type_q <= cfg_data_i;
    end
  end

  assign accept = push_i & ~full_o;

  mcl_parser u_parser (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .accept_i      (accept),
    .data_byte_i   (data_byte_i),
    .last_byte_i   (last_byte_i),
    .target_type_i (target_type_q),
    .res_push_o    (res_push),
    .res_o         (res_in)
  );

  mcl_queue #(
    .Depth (QueueDepth)
  ) u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (res_push),
    .data_i  (res_in),
    .pop_i   (pop_i),
    .data_o  (res_out),
    .empty_o (empty_o),
    .full_o  (full_o)
  );

  assign status_o       = res_out.status;
  assign version_o      = res_out.version;
  assign data_offset_o  = res_out.data_offset;
  assign data_len_o     = res_out.data_len;
  assign chunk_number_o = res_out.chunk_number;

  `MCL_ASSERT(a_push_only_on_accept, !res_push || (push_i && !full_o), "result without request")
  `MCL_ASSERT_NEXT(a_push_shows, res_push && !(pop_i && !empty_o), !empty_o, "result lost")
  `MCL_ASSERT(a_found_offset,
              empty_o || status_o != mcl_pkg::StatFound || data_offset_o >= 17'd6,
              "found offset below header")
  `MCL_ASSERT(a_miss_zero,
              empty_o || status_o == mcl_pkg::StatFound ||
              (data_len_o == 16'd0 && data_offset_o == 17'd0),
              "miss carries data fields")

endmodule
